[rtl/core/sds_pkg.sv]
package sds_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 17;
    localparam int LANE_W  = 3;
    localparam int DT_W    = 16;
    localparam int GAIN_W  = 24;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int Q_SHIFT = 16;
    localparam int SHR_W   = PROD_W - Q_SHIFT;
    localparam int SUM_W   = SHR_W + 1;
    localparam int FIELDS  = 4;
    localparam int PC_W    = 4;

    localparam logic [1:0] CFG_FORCE    = 2'd0;
    localparam logic [1:0] CFG_FRICTION = 2'd1;
    localparam logic [1:0] CFG_SNAP     = 2'd2;
    localparam logic [1:0] CFG_LANES    = 2'd3;

    localparam logic [CFG_W-1:0]  FORCE_RESET    = 17'd39322;
    localparam logic [CFG_W-1:0]  FRICTION_RESET = 17'd13107;
    localparam logic [CFG_W-1:0]  SNAP_RESET     = 17'd7;
    localparam logic [LANE_W-1:0] LANES_RESET    = 3'd1;

    localparam logic signed [SUM_W-1:0] SAT_MAX = 43'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -43'sd2147483648;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LATCH_IN,
        OP_LOAD,
        OP_TERM1,
        OP_ACC,
        OP_SPD,
        OP_VAL,
        OP_PUBLISH
    } t_op;

    typedef enum logic [1:0] {
        A_DIFF,
        A_SPD,
        A_ACC,
        A_NSPD
    } t_asel;

    typedef enum logic [1:0] {
        B_FORCE,
        B_FRIC,
        B_DT
    } t_bsel;

    typedef enum logic [2:0] {
        J_NEXT,
        J_WAIT_IN,
        J_NOLANES,
        J_LANE,
        J_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_op   op;
        t_asel asel;
        t_bsel bsel;
        logic  mul_en;
        t_jmp  jmp;
        t_pc   target;
    } t_uop;

    typedef struct packed {
        t_op   op;
        t_asel asel;
        t_bsel bsel;
        logic  mul_en;
    } t_dp_ctl;

    typedef struct packed {
        logic more_lanes;
        logic no_lanes;
        logic out_full;
    } t_dp_status;

    localparam t_pc PC_IDLE   = 4'd0;
    localparam t_pc PC_CHECK  = 4'd1;
    localparam t_pc PC_LOAD   = 4'd2;
    localparam t_pc PC_FINISH = 4'd10;

    // Microprogram: one lane takes the steps from PC_LOAD to the lane jump.
    function automatic t_uop ucode(input t_pc pc);
        t_uop u;
        u = '{op: OP_NOP, asel: A_DIFF, bsel: B_FORCE, mul_en: 1'b0,
              jmp: J_NEXT, target: PC_IDLE};
        unique case (pc)
            4'd0: begin
                u.op = OP_LATCH_IN;
                u.jmp = J_WAIT_IN;
            end
            4'd1: begin
                u.jmp = J_NOLANES;
                u.target = PC_FINISH;
            end
            4'd2: u.op = OP_LOAD;
            4'd3: begin
                u.mul_en = 1'b1;
                u.asel = A_DIFF;
                u.bsel = B_FORCE;
            end
            4'd4: begin
                u.op = OP_TERM1;
                u.mul_en = 1'b1;
                u.asel = A_SPD;
                u.bsel = B_FRIC;
            end
            4'd5: u.op = OP_ACC;
            4'd6: begin
                u.mul_en = 1'b1;
                u.asel = A_ACC;
                u.bsel = B_DT;
            end
            4'd7: u.op = OP_SPD;
            4'd8: begin
                u.mul_en = 1'b1;
                u.asel = A_NSPD;
                u.bsel = B_DT;
            end
            4'd9: begin
                u.op = OP_VAL;
                u.jmp = J_LANE;
                u.target = PC_LOAD;
            end
            4'd10: begin
                u.op = OP_PUBLISH;
                u.jmp = J_WAIT_OUT;
                u.target = PC_IDLE;
            end
            default: begin
                u.jmp = J_WAIT_OUT;
                u.target = PC_IDLE;
            end
        endcase
        return u;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        if (x > SAT_MAX) begin
            return SAT_MAX[DATA_W-1:0];
        end else if (x < SAT_MIN) begin
            return SAT_MIN[DATA_W-1:0];
        end
        return x[DATA_W-1:0];
    endfunction

    // Times 100 as shifts and adds: 64 + 32 + 4.
    function automatic logic [GAIN_W-1:0] scale100(input logic [CFG_W-1:0] x);
        return {1'b0, x, 6'b0} + {2'b0, x, 5'b0} + {5'b0, x, 2'b0};
    endfunction

endpackage

[rtl/core/sds_sequencer.sv]
module sds_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  sds_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output sds_pkg::t_dp_ctl    o_ctl
);

    sds_pkg::t_pc  r_pc;
    sds_pkg::t_pc  n_pc;
    sds_pkg::t_uop uop;
    logic          go;

    assign uop = sds_pkg::ucode(r_pc);

    // Waiting steps only perform their operation once the handshake allows it.
    always_comb begin
        go = 1'b1;
        unique case (uop.jmp)
            sds_pkg::J_WAIT_IN:  go = i_in_valid;
            sds_pkg::J_WAIT_OUT: go = !i_status.out_full || i_out_ready;
            default:             go = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = r_pc + sds_pkg::t_pc'(1);
        unique case (uop.jmp)
            sds_pkg::J_WAIT_IN:  n_pc = go ? r_pc + sds_pkg::t_pc'(1) : r_pc;
            sds_pkg::J_NOLANES:  if (i_status.no_lanes) n_pc = uop.target;
            sds_pkg::J_LANE:     if (i_status.more_lanes) n_pc = uop.target;
            sds_pkg::J_WAIT_OUT: n_pc = go ? uop.target : r_pc;
            default:             n_pc = r_pc + sds_pkg::t_pc'(1);
        endcase
    end

    always_comb begin
        o_in_ready   = (uop.jmp == sds_pkg::J_WAIT_IN);
        o_ctl.op     = go ? uop.op : sds_pkg::OP_NOP;
        o_ctl.asel   = uop.asel;
        o_ctl.bsel   = uop.bsel;
        o_ctl.mul_en = uop.mul_en && go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= sds_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[rtl/core/sds_datapath.sv]
module sds_datapath #(
    parameter int LANES = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  sds_pkg::t_dp_ctl                            i_ctl,
    input  logic [sds_pkg::FIELDS*sds_pkg::DATA_W-1:0]  i_targets,
    input  logic [sds_pkg::DT_W-1:0]                    i_dt,
    input  logic [sds_pkg::GAIN_W-1:0]                  i_force,
    input  logic [sds_pkg::GAIN_W-1:0]                  i_fric,
    input  logic [sds_pkg::CFG_W-1:0]                   i_snap_thr,
    input  logic [sds_pkg::LANE_W-1:0]                  i_active,
    input  logic                                        i_out_ready,
    output sds_pkg::t_dp_status                         o_status,
    output logic                                        o_out_valid,
    output logic [sds_pkg::FIELDS*sds_pkg::DATA_W-1:0]  o_out_data
);

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int DW = sds_pkg::DATA_W;

    logic signed [DW-1:0] r_val [LANES];
    logic signed [DW-1:0] r_spd [LANES];
    logic signed [DW-1:0] r_tgt [LANES];
    logic [sds_pkg::DT_W-1:0] r_dt;
    logic [LW-1:0] r_lane;

    logic signed [DW-1:0]                 r_w_tgt;
    logic signed [DW-1:0]                 r_w_val;
    logic signed [DW-1:0]                 r_w_spd;
    logic signed [DW:0]                   r_diff;
    logic signed [sds_pkg::PROD_W-1:0]    r_prod;
    logic signed [sds_pkg::SHR_W-1:0]     r_term1;
    logic signed [DW-1:0]                 r_acc;
    logic signed [DW-1:0]                 r_nspd;
    logic                                 r_out_valid;
    logic [sds_pkg::FIELDS*DW-1:0]        r_out_data;

    logic signed [sds_pkg::MUL_A_W-1:0] mul_a;
    logic signed [sds_pkg::MUL_B_W-1:0] mul_b;
    logic signed [sds_pkg::SHR_W-1:0]   prod_sh;
    logic signed [sds_pkg::SUM_W-1:0]   acc_sum;
    logic signed [sds_pkg::SUM_W-1:0]   spd_sum;
    logic signed [sds_pkg::SUM_W-1:0]   val_sum;
    logic signed [DW-1:0]               nval_sat;
    logic signed [DW:0]                 err;
    logic [DW:0]                        err_abs;
    logic [DW:0]                        acc_abs;
    logic [DW:0]                        thr;
    logic                               snap;
    logic [sds_pkg::LANE_W-1:0]         lane_next;
    logic [DW-1:0]                      out_word [sds_pkg::FIELDS];

    always_comb begin
        case (i_ctl.asel)
            sds_pkg::A_DIFF: mul_a = r_diff;
            sds_pkg::A_SPD:  mul_a = {r_w_spd[DW-1], r_w_spd};
            sds_pkg::A_ACC:  mul_a = {r_acc[DW-1], r_acc};
            default:         mul_a = {r_nspd[DW-1], r_nspd};
        endcase
        case (i_ctl.bsel)
            sds_pkg::B_FORCE: mul_b = {1'b0, i_force};
            sds_pkg::B_FRIC:  mul_b = {1'b0, i_fric};
            default:          mul_b = {{(sds_pkg::MUL_B_W - sds_pkg::DT_W){1'b0}}, r_dt};
        endcase
    end

    // The arithmetic shift of the product rounds toward minus infinity.
    assign prod_sh  = r_prod[sds_pkg::PROD_W-1:sds_pkg::Q_SHIFT];
    assign acc_sum  = {r_term1[sds_pkg::SHR_W-1], r_term1} - {prod_sh[sds_pkg::SHR_W-1], prod_sh};
    assign spd_sum  = {{(sds_pkg::SUM_W - DW){r_w_spd[DW-1]}}, r_w_spd}
                    + {prod_sh[sds_pkg::SHR_W-1], prod_sh};
    assign val_sum  = {{(sds_pkg::SUM_W - DW){r_w_val[DW-1]}}, r_w_val}
                    + {prod_sh[sds_pkg::SHR_W-1], prod_sh};
    assign nval_sat = sds_pkg::sat32(val_sum);

    assign err     = {nval_sat[DW-1], nval_sat} - {r_w_tgt[DW-1], r_w_tgt};
    assign err_abs = err[DW] ? -err : err;
    assign acc_abs = r_acc[DW-1] ? -{r_acc[DW-1], r_acc} : {1'b0, r_acc};
    assign thr     = {{(DW + 1 - sds_pkg::CFG_W){1'b0}}, i_snap_thr};
    assign snap    = (err_abs < thr) && (acc_abs < thr);

    assign lane_next = sds_pkg::LANE_W'(r_lane) + sds_pkg::LANE_W'(1);

    assign o_status.more_lanes = (lane_next < i_active);
    assign o_status.no_lanes   = (i_active == '0);
    assign o_status.out_full   = r_out_valid;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out_data;

    for (genvar g = 0; g < sds_pkg::FIELDS; g++) begin : g_out
        if (g < LANES) begin : g_lane
            assign out_word[g] = r_val[g];
        end else begin : g_none
            assign out_word[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_ctl.op)
            sds_pkg::OP_LATCH_IN: begin
                for (int i = 0; i < LANES; i++) begin
                    r_tgt[i] <= i_targets[DW*i +: DW];
                end
                r_dt <= i_dt;
            end
            sds_pkg::OP_LOAD: begin
                r_w_tgt <= r_tgt[r_lane];
                r_w_val <= r_val[r_lane];
                r_w_spd <= r_spd[r_lane];
                r_diff  <= {r_tgt[r_lane][DW-1], r_tgt[r_lane]}
                         - {r_val[r_lane][DW-1], r_val[r_lane]};
            end
            sds_pkg::OP_TERM1: r_term1 <= prod_sh;
            sds_pkg::OP_ACC:   r_acc   <= sds_pkg::sat32(acc_sum);
            sds_pkg::OP_SPD:   r_nspd  <= sds_pkg::sat32(spd_sum);
            sds_pkg::OP_PUBLISH: begin
                for (int i = 0; i < sds_pkg::FIELDS; i++) begin
                    r_out_data[DW*i +: DW] <= out_word[i];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_val[i] <= '0;
                r_spd[i] <= '0;
            end
            r_lane      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.op == sds_pkg::OP_LATCH_IN) begin
                r_lane <= '0;
            end else if (i_ctl.op == sds_pkg::OP_VAL) begin
                r_val[r_lane] <= snap ? r_w_tgt : nval_sat;
                r_spd[r_lane] <= r_nspd;
                r_lane        <= LW'(r_lane + 1'b1);
            end
            if (i_ctl.op == sds_pkg::OP_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/spring_damper_smoother_core.sv]
// Mass-spring-damper smoother for up to four Q16.16 value lanes.
//
// Input stream (s side): one transaction is one time step carrying four
// targets and the elapsed time. Output stream (m side): one transaction per
// input, carrying the new smoothed value of every lane; lanes that are not
// in use repeat their held value, lanes beyond LANES read as zero.
// Configuration is a plain write port, to be used only while the block is
// idle: index 0 force gain, 1 friction gain, 2 snap threshold, 3 lanes in use.
//
// Sequencing: the microprogram feeds a single shared 33 x 25 multiplier
// four times per lane, and the lanes in use are processed one after another.
// A new item is taken only when the sequencer is back in its idle step, so
// the block takes no new item before the last result is in the output register.
//
// Reset clears every lane's value and speed and loads the default settings.
// When the receiver stalls, the finished result waits in the output
// register and the sequencer holds in its publish step until it can load
// the next one; no result is lost or repeated.
module spring_damper_smoother_core #(
    parameter int LANES = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // Fields from bit 0 up: target_0, target_1, target_2, target_3, step_time.
    input  logic [143:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // Fields from bit 0 up: smoothed_0, smoothed_1, smoothed_2, smoothed_3.
    output logic [127:0] o_m_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [16:0]  i_cfg_wdata
);

    localparam int TGT_BITS = sds_pkg::FIELDS * sds_pkg::DATA_W;

    // The gains are kept already multiplied by 100, so the multiply loop
    // never has to apply the fixed scale itself.
    logic [sds_pkg::GAIN_W-1:0] r_force_scaled;
    logic [sds_pkg::GAIN_W-1:0] r_fric_scaled;
    logic [sds_pkg::CFG_W-1:0]  r_snap_thr;
    logic [sds_pkg::LANE_W-1:0] r_lanes;
    logic [sds_pkg::LANE_W-1:0] active;

    sds_pkg::t_dp_ctl    ctl;
    sds_pkg::t_dp_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_scaled <= sds_pkg::scale100(sds_pkg::FORCE_RESET);
            r_fric_scaled  <= sds_pkg::scale100(sds_pkg::FRICTION_RESET);
            r_snap_thr     <= sds_pkg::SNAP_RESET;
            r_lanes        <= sds_pkg::LANES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sds_pkg::CFG_FORCE:    r_force_scaled <= sds_pkg::scale100(i_cfg_wdata);
                sds_pkg::CFG_FRICTION: r_fric_scaled  <= sds_pkg::scale100(i_cfg_wdata);
                sds_pkg::CFG_SNAP:     r_snap_thr     <= i_cfg_wdata;
                default:               r_lanes        <= i_cfg_wdata[sds_pkg::LANE_W-1:0];
            endcase
        end
    end

    // A lane count above the number of built lanes processes all of them.
    assign active = (r_lanes > sds_pkg::LANE_W'(LANES)) ? sds_pkg::LANE_W'(LANES) : r_lanes;

    sds_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (status),
        .o_in_ready  (o_s_tready),
        .o_ctl       (ctl)
    );

    sds_datapath #(
        .LANES (LANES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_targets   (i_s_tdata[TGT_BITS-1:0]),
        .i_dt        (i_s_tdata[TGT_BITS +: sds_pkg::DT_W]),
        .i_force     (r_force_scaled),
        .i_fric      (r_fric_scaled),
        .i_snap_thr  (r_snap_thr),
        .i_active    (active),
        .i_out_ready (i_m_tready),
        .o_status    (status),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );

endmodule

[tb/tb.sv]
// Scoreboard for the spring-damper smoother. It keeps its own copy of every
// lane's value and speed and of the four settings. Each accepted input
// transaction advances that copy by one time step, and the new smoothed
// values are queued until the block offers its result.
class smoother_scoreboard;
    localparam int LANE_COUNT = 4;

    int lane_value[LANE_COUNT];
    int lane_speed[LANE_COUNT];
    int force_gain;
    int friction_gain;
    int snap_limit;
    int lanes_used;
    logic [127:0] expected_steps[$];
    int errors;

    function new();
        foreach (lane_value[i]) begin
            lane_value[i] = 0;
            lane_speed[i] = 0;
        end
        force_gain    = sds_pkg::FORCE_RESET;
        friction_gain = sds_pkg::FRICTION_RESET;
        snap_limit    = sds_pkg::SNAP_RESET;
        lanes_used    = sds_pkg::LANES_RESET;
        errors        = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [16:0] data);
        case (index)
            sds_pkg::CFG_FORCE:    force_gain = data;
            sds_pkg::CFG_FRICTION: friction_gain = data;
            sds_pkg::CFG_SNAP:     snap_limit = data;
            sds_pkg::CFG_LANES:    lanes_used = data[2:0];
            default: ;
        endcase
    endfunction

    static function longint clamp32(longint x);
        if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function int pending();
        return expected_steps.size();
    endfunction

    // One time step. Products are exact in 64 bits and the arithmetic
    // right shift by 16 rounds toward minus infinity.
    function void note_step(logic [143:0] step);
        longint dt, tgt, val, spd, acc, nspd, nval, miss;
        logic signed [31:0] tgt32;
        int active;
        logic [127:0] smoothed;
        dt = longint'(step[143:128]);
        active = (lanes_used > LANE_COUNT) ? LANE_COUNT : lanes_used;
        smoothed = '0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            if (i >= active) begin
                // A lane that is not in use repeats its held value.
                smoothed[i*32 +: 32] = lane_value[i];
            end else begin
                tgt32 = step[i*32 +: 32];
                tgt = tgt32;
                val = lane_value[i];
                spd = lane_speed[i];
                acc = (((tgt - val) * force_gain * 100) >>> 16)
                    - ((spd * friction_gain * 100) >>> 16);
                acc = clamp32(acc);
                nspd = clamp32(spd + ((acc * dt) >>> 16));
                nval = clamp32(val + ((nspd * dt) >>> 16));
                miss = nval - tgt;
                // Close enough and barely accelerating: land on the target.
                // The speed is kept as computed.
                if ((miss < 0 ? -miss : miss) < snap_limit &&
                    (acc < 0 ? -acc : acc) < snap_limit) begin
                    nval = tgt;
                end
                lane_speed[i] = int'(nspd);
                lane_value[i] = int'(nval);
                smoothed[i*32 +: 32] = nval[31:0];
            end
        end
        expected_steps.push_back(smoothed);
    endfunction

    function void check_output(logic [127:0] got);
        logic [127:0] want;
        if (expected_steps.size() == 0) begin
            errors++;
            $display("%0t: output transaction with nothing expected, got %h", $time, got);
            return;
        end
        want = expected_steps.pop_front();
        for (int i = 0; i < LANE_COUNT; i++) begin
            if (got[i*32 +: 32] !== want[i*32 +: 32]) begin
                errors++;
                $display("%0t: smoothed_%0d expected %0d, actual %0d", $time, i,
                         $signed(want[i*32 +: 32]), $signed(got[i*32 +: 32]));
            end
        end
    endfunction
endclass

module tb;

    // The limit allows for the slowest item and for the longest sender gaps
    // and receiver stalls many times over.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 40;

    typedef enum {
        AIM_FULL,
        AIM_MAX,
        AIM_MIN,
        AIM_ZERO,
        AIM_SMALL,
        AIM_NEAR
    } aim_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [16:0]  cfg_wdata;

    logic [31:0]  next_target[4];
    bit           tx_throttle;
    bit           rx_throttle;
    int           rx_hold = 0;
    int           idle_cycles = 0;

    smoother_scoreboard sb;

    spring_damper_smoother_core #(
        .LANES(4)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [16:0] pick_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 17'd0;
        end else if (r == 1) begin
            return 17'd65536;
        end else if (r == 2) begin
            return 17'($urandom_range(65537, 131071));
        end
        return 17'($urandom_range(0, 65536));
    endfunction

    function automatic logic [31:0] aim_lane(int lane, aim_t how);
        case (how)
            AIM_MAX:   return 32'h7FFF_FFFF;
            AIM_MIN:   return 32'h8000_0000;
            AIM_ZERO:  return 32'h0;
            AIM_SMALL: return $urandom_range(0, 2097152) - 1048576;
            // Just off the lane's current value, where snapping can happen.
            AIM_NEAR:  return sb.lane_value[lane] + $urandom_range(0, 128) - 64;
            default:   return $urandom();
        endcase
    endfunction

    // Receiver side: runs of ready broken by stalls of random length.
    always @(negedge clk) begin
        if (!rx_throttle) begin
            m_tready = 1'b1;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            rx_hold--;
        end else if (m_tready) begin
            rx_hold = pick_gap();
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end
        end else begin
            m_tready = 1'b1;
            rx_hold = $urandom_range(0, 7);
        end
    end

    // Every accepted transaction on either side goes to the scoreboard.
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.note_step(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_output(m_tdata);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offers one time step built from next_target and waits for acceptance.
    // tvalid stays high on return so back-to-back steps need no toggle.
    task automatic send_step(input logic [15:0] dt);
        int gap;
        gap = tx_throttle ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = {dt, next_target[3], next_target[2], next_target[1], next_target[0]};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic set_all_targets(input aim_t how);
        for (int i = 0; i < 4; i++) begin
            next_target[i] = aim_lane(i, how);
        end
    endtask

    // Drops tvalid and waits until every result has come back.
    task automatic finish_phase();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [16:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_wdata = data;
        sb.write_reg(index, data);
    endtask

    task automatic apply_settings(input logic [16:0] force_val, input logic [16:0] fric_val,
                                  input logic [16:0] thr_val, input logic [2:0] lanes_val);
        write_reg(sds_pkg::CFG_FORCE, force_val);
        write_reg(sds_pkg::CFG_FRICTION, fric_val);
        write_reg(sds_pkg::CFG_SNAP, thr_val);
        write_reg(sds_pkg::CFG_LANES, {14'd0, lanes_val});
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial begin
        int r;
        logic [16:0] thr;
        logic [2:0] lanes;
        logic [15:0] dt;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
        foreach (next_target[i]) next_target[i] = '0;
        sb = new();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: one lane, default gains.
        set_all_targets(AIM_MAX);
        send_step(16'hFFFF);
        set_all_targets(AIM_MIN);
        send_step(16'hFFFF);
        set_all_targets(AIM_ZERO);
        send_step(16'h0000);
        finish_phase();

        // Unity gains, all lanes, target extremes, longest and zero steps.
        apply_settings(17'd65536, 17'd65536, 17'd65536, 3'd4);
        next_target[0] = 32'h7FFF_FFFF;
        next_target[1] = 32'h8000_0000;
        next_target[2] = 32'h0000_0000;
        next_target[3] = 32'hFFFF_FFFF;
        send_step(16'hFFFF);
        send_step(16'h0000);
        send_step(16'h0001);
        set_all_targets(AIM_NEAR);
        send_step(16'h0000);
        finish_phase();

        // No lane in use: every lane holds.
        apply_settings(17'd0, 17'd0, 17'd0, 3'd0);
        set_all_targets(AIM_FULL);
        send_step(16'hFFFF);
        set_all_targets(AIM_FULL);
        send_step(16'($urandom_range(0, 65535)));
        finish_phase();

        // Gains above one and a lane count above the lane limit.
        apply_settings(17'd131071, 17'd131071, 17'd131071, 3'd7);
        set_all_targets(AIM_FULL);
        send_step(16'hFFFF);
        set_all_targets(AIM_SMALL);
        send_step(16'd1000);
        send_step(16'h0000);
        finish_phase();

        // No spring and no friction: acc is zero, so a target just off the
        // held value snaps, including on a zero time step.
        apply_settings(17'd0, 17'd0, 17'd131071, 3'd4);
        set_all_targets(AIM_NEAR);
        send_step(16'h0000);
        set_all_targets(AIM_NEAR);
        send_step(16'h0000);
        set_all_targets(AIM_NEAR);
        send_step(16'($urandom_range(0, 65535)));
        finish_phase();

        apply_settings(17'd39322, 17'd13107, 17'd7, 3'd3);
        set_all_targets(AIM_SMALL);
        send_step(16'd4096);
        send_step(16'd4096);
        send_step(16'd4096);
        finish_phase();

        // Random phases. Targets are mostly held for a while so the lanes
        // settle toward them, with jumps and extremes in between.
        for (int phase = 0; phase < PHASES; phase++) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                thr = 17'd0;
            end else if (r == 1) begin
                thr = 17'd131071;
            end else if (r < 5) begin
                thr = 17'($urandom_range(0, 64));
            end else begin
                thr = 17'($urandom_range(0, 65536));
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                lanes = 3'd0;
            end else if (r == 1) begin
                lanes = 3'($urandom_range(5, 7));
            end else begin
                lanes = 3'($urandom_range(1, 4));
            end
            apply_settings(pick_gain(), pick_gain(), thr, lanes);
            tx_throttle = ($urandom_range(0, 3) != 0);
            rx_throttle = ($urandom_range(0, 3) != 0);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == 0 || $urandom_range(0, 9) < 4) begin
                    for (int i = 0; i < 4; i++) begin
                        r = $urandom_range(0, 9);
                        next_target[i] = aim_lane(i, r < 1 ? AIM_MAX :
                                                     r < 2 ? AIM_MIN :
                                                     r < 3 ? AIM_ZERO :
                                                     r < 5 ? AIM_SMALL :
                                                     r < 8 ? AIM_NEAR : AIM_FULL);
                    end
                end
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    dt = 16'h0000;
                end else if (r == 1) begin
                    dt = 16'hFFFF;
                end else if (r < 5) begin
                    dt = 16'($urandom_range(0, 65535));
                end else begin
                    dt = 16'($urandom_range(1, 4096));
                end
                send_step(dt);
            end
            finish_phase();
        end

        rx_throttle = 1'b1;
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/sds_pkg.sv
rtl/core/sds_sequencer.sv
rtl/core/sds_datapath.sv
rtl/core/spring_damper_smoother_core.sv
tb/tb.sv
